// ===== rtl/core/sdff_pkg.sv =====
// shared types and constants of the signed decimal field formatter
`timescale 1ns / 1ps

package sdff_pkg;

  // magnitude and decimal digit sizes
  localparam int MAG_W     = 64;
  localparam int DIG_N     = 20;
  localparam int BCD_W     = 4 * DIG_N;
  localparam int DIG_W     = $clog2(DIG_N + 1);
  localparam int STEP_W    = $clog2(MAG_W);
  localparam int TEXT_MAX  = DIG_N + 1;
  localparam int FW_W      = 6;
  localparam int CMP_W     = 7;
  localparam int DEF_MAX_WIDTH = 63;

  // ascii codes
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_PLUS  = 8'h2B;
  localparam logic [7:0] ASCII_SPACE = 8'h20;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_EMIT
  } state_t;

  // shift unit operations
  typedef enum logic [1:0] {
    OP_NOP,
    OP_LOAD,
    OP_DABBLE,
    OP_SHIFT4
  } bcd_op_t;

  typedef struct packed {
    bcd_op_t op;
  } bcd_ctl_t;

  typedef struct packed {
    logic [3:0] top_digit;
    logic       top_zero;
  } bcd_stat_t;

endpackage

// ===== rtl/core/sdff_bcd.sv =====
// shared shift unit: double dabble conversion and digit shifting
`timescale 1ns / 1ps

module sdff_bcd (
  input  logic                        clk,
  input  logic [sdff_pkg::MAG_W-1:0]  value,
  input  sdff_pkg::bcd_ctl_t          ctl,
  output sdff_pkg::bcd_stat_t         stat
);

  logic [sdff_pkg::MAG_W-1:0] mag;
  logic [sdff_pkg::BCD_W-1:0] bcd;
  logic [sdff_pkg::BCD_W-1:0] bcd_adj;

  // add three to every digit of five or more
  always_comb begin
    for (int i = 0; i < sdff_pkg::DIG_N; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // load magnitude, shift one bit in, or shift one digit out
  always_ff @(posedge clk) begin
    case (ctl.op)
      sdff_pkg::OP_LOAD: begin
        mag <= value[sdff_pkg::MAG_W-1] ? (~value + 1'b1) : value;
        bcd <= '0;
      end
      sdff_pkg::OP_DABBLE: begin
        bcd <= {bcd_adj[sdff_pkg::BCD_W-2:0], mag[sdff_pkg::MAG_W-1]};
        mag <= {mag[sdff_pkg::MAG_W-2:0], 1'b0};
      end
      sdff_pkg::OP_SHIFT4: begin
        bcd <= {bcd[sdff_pkg::BCD_W-5:0], 4'd0};
      end
      default: begin
      end
    endcase
  end

  // most significant digit
  assign stat.top_digit = bcd[sdff_pkg::BCD_W-1 -: 4];
  assign stat.top_zero  = (bcd[sdff_pkg::BCD_W-1 -: 4] == 4'd0);

endmodule

// ===== rtl/core/sdff_seq.sv =====
// sequencer: conversion steps, digit count, field layout and character output
`timescale 1ns / 1ps

module sdff_seq #(
  parameter int MAX_WIDTH = sdff_pkg::DEF_MAX_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic                        value_neg,
  input  logic [sdff_pkg::FW_W-1:0]   field_width,
  input  logic                        pad_zero,
  input  logic                        left_justify,
  input  logic                        force_plus,
  output sdff_pkg::bcd_ctl_t          ctl,
  input  sdff_pkg::bcd_stat_t         stat,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,
  output logic                        m_tlast
);

  localparam int LIM = (MAX_WIDTH > sdff_pkg::TEXT_MAX) ? MAX_WIDTH : sdff_pkg::TEXT_MAX;
  localparam int CW  = $clog2(LIM + 1);

  sdff_pkg::state_t state, state_next;

  logic [sdff_pkg::STEP_W-1:0] step;
  logic [sdff_pkg::DIG_W-1:0]  nd;
  logic                        has_sign;
  logic [7:0]                  sign_ch;
  logic                        zero_mode;
  logic                        left;
  logic [CW-1:0]               width;
  logic [CW-1:0]               pos;
  logic [CW-1:0]               total;
  logic [CW-1:0]               sign_pos;
  logic [CW-1:0]               dig_start;
  logic [CW-1:0]               dig_end;

  logic                        accept;
  logic                        out_free;
  logic                        emit;
  logic                        norm_go;
  logic                        conv_done;
  logic [CW-1:0]               text_len;
  logic [CW-1:0]               total_calc;
  logic [CW-1:0]               pad;
  logic [CW-1:0]               start_calc;
  logic [CW-1:0]               width_clip;
  logic                        is_sign;
  logic                        in_digits;
  logic                        is_last;
  logic [7:0]                  char;

  // handshakes and status
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign emit      = (state == sdff_pkg::ST_EMIT) && out_free;
  assign norm_go   = stat.top_zero && (nd != sdff_pkg::DIG_W'(1));
  assign conv_done = (step == sdff_pkg::STEP_W'(sdff_pkg::MAG_W - 1));

  // saturate the requested width
  always_comb begin
    if ({1'b0, field_width} > sdff_pkg::CMP_W'(MAX_WIDTH)) begin
      width_clip = CW'(MAX_WIDTH);
    end else begin
      width_clip = CW'(field_width);
    end
  end

  // field layout from digit count
  assign text_len   = CW'(nd) + CW'(has_sign);
  assign total_calc = (width > text_len) ? width : text_len;
  assign pad        = total_calc - text_len;
  assign start_calc = left ? CW'(has_sign) : (pad + CW'(has_sign));

  // character at the current position
  assign is_sign   = has_sign && (pos == sign_pos);
  assign in_digits = (pos >= dig_start) && (pos < dig_end);
  assign is_last   = (pos == total - CW'(1));

  always_comb begin
    if (is_sign) begin
      char = sign_ch;
    end else if (in_digits) begin
      char = sdff_pkg::ASCII_ZERO + {4'd0, stat.top_digit};
    end else if (zero_mode) begin
      char = sdff_pkg::ASCII_ZERO;
    end else begin
      char = sdff_pkg::ASCII_SPACE;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sdff_pkg::ST_IDLE: begin
        if (accept) state_next = sdff_pkg::ST_CONV;
      end
      sdff_pkg::ST_CONV: begin
        if (conv_done) state_next = sdff_pkg::ST_NORM;
      end
      sdff_pkg::ST_NORM: begin
        if (!norm_go) state_next = sdff_pkg::ST_EMIT;
      end
      sdff_pkg::ST_EMIT: begin
        if (emit && is_last) state_next = sdff_pkg::ST_IDLE;
      end
      default: begin
        state_next = sdff_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready = 1'b0;
    ctl.op   = sdff_pkg::OP_NOP;
    case (state)
      sdff_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) ctl.op = sdff_pkg::OP_LOAD;
      end
      sdff_pkg::ST_CONV: begin
        ctl.op = sdff_pkg::OP_DABBLE;
      end
      sdff_pkg::ST_NORM: begin
        if (norm_go) ctl.op = sdff_pkg::OP_SHIFT4;
      end
      sdff_pkg::ST_EMIT: begin
        if (emit && in_digits && !is_sign) ctl.op = sdff_pkg::OP_SHIFT4;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sdff_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // item and layout registers
  always_ff @(posedge clk) begin
    case (state)
      sdff_pkg::ST_IDLE: begin
        if (accept) begin
          width     <= width_clip;
          has_sign  <= value_neg || force_plus;
          sign_ch   <= value_neg ? sdff_pkg::ASCII_MINUS : sdff_pkg::ASCII_PLUS;
          zero_mode <= pad_zero && !left_justify;
          left      <= left_justify;
          step      <= '0;
          nd        <= sdff_pkg::DIG_W'(sdff_pkg::DIG_N);
        end
      end
      sdff_pkg::ST_CONV: begin
        step <= step + 1'b1;
      end
      sdff_pkg::ST_NORM: begin
        if (norm_go) begin
          nd <= nd - 1'b1;
        end else begin
          total     <= total_calc;
          sign_pos  <= (left || zero_mode) ? '0 : pad;
          dig_start <= start_calc;
          dig_end   <= start_calc + CW'(nd);
          pos       <= '0;
        end
      end
      sdff_pkg::ST_EMIT: begin
        if (emit) pos <= pos + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // output character register
  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= char;
      m_tlast <= is_last;
    end
  end

  // checks
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    (emit && in_digits && !is_sign) |-> (stat.top_digit <= 4'd9))
    else $error("non decimal digit emitted");

  a_conv_to_norm: assert property (@(posedge clk) disable iff (rst)
    (state == sdff_pkg::ST_CONV && conv_done) |=> (state == sdff_pkg::ST_NORM))
    else $error("conversion did not end after all steps");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (state == sdff_pkg::ST_EMIT) |-> (pos < total))
    else $error("position beyond field length");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && is_last) |=> (state == sdff_pkg::ST_IDLE && m_tvalid && m_tlast))
    else $error("last character not followed by idle");

endmodule

// ===== rtl/core/signed_decimal_field_formatter.sv =====
// Signed decimal field formatter: one signed 64-bit value in, printf-style
// decimal text out, one ASCII character per transfer.
//
// Input channel s_*: one transfer carries the value and its format flags
// (field width, zero padding, left justify, forced plus). Output channel m_*:
// one transfer per character, left to right, m_tlast on the final character.
//
// Steps per item: the accept, 64 shift steps of the binary to BCD unit, then
// leading zero digits are dropped one at a time through the same shifter, then
// one character per cycle while the receiver does not stall, max(text length,
// width) of them. s_tready is high only while no item is in work. The final
// character sits in the output register, so the next item can be accepted
// before it is taken.
//
// A stalled receiver holds m_tdata and m_tlast and pauses the character
// sequencer. Synchronous reset drops any item in work and clears m_tvalid.
`timescale 1ns / 1ps

module signed_decimal_field_formatter #(
  parameter int MAX_WIDTH = sdff_pkg::DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // value[63:0], field_width[69:64], pad_zero[70],
                                 // left_justify[71], force_plus[72], zero[79:73]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_char[7:0]
  output logic        m_tlast
);

  sdff_pkg::bcd_ctl_t  ctl;
  sdff_pkg::bcd_stat_t stat;

  // shared shift unit
  sdff_bcd u_bcd (
    .clk   (clk),
    .value (s_tdata[63:0]),
    .ctl   (ctl),
    .stat  (stat)
  );

  // sequencer and output register
  sdff_seq #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .value_neg    (s_tdata[63]),
    .field_width  (s_tdata[69:64]),
    .pad_zero     (s_tdata[70]),
    .left_justify (s_tdata[71]),
    .force_plus   (s_tdata[72]),
    .ctl          (ctl),
    .stat         (stat),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast)
  );

endmodule
